### design/nearest_point_on_segments_defines.svh
// Assertion macros shared by the nearest point on segments RTL.
`ifndef NEAREST_POINT_ON_SEGMENTS_DEFINES_SVH
`define NEAREST_POINT_ON_SEGMENTS_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define NPOS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NPOS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/npos_pkg.sv
// Shared types and constants for the nearest point on segments block.
`default_nettype none
package npos_pkg;

  localparam int COORD_W           = 18;
  localparam int IDX_W             = 9;
  localparam int CNT_W             = 9;
  localparam int SEG_OUT_W         = 8;
  localparam int DIST_W            = 37;
  localparam int DIFF_W            = COORD_W + 1;
  localparam int PROD_W            = 2 * DIFF_W;
  localparam int SQS_W             = PROD_W;
  localparam int DOT_W             = PROD_W + 1;
  localparam int POINT_W           = 2 * COORD_W;
  localparam int IN_TDATA_W        = 48;
  localparam int OUT_TDATA_W       = 88;
  localparam int DEF_MAX_SEGMENTS  = 256;
  localparam int DEF_FRACTION_BITS = 16;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage
`default_nettype wire

### design/npos_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module npos_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### design/npos_div.sv
// Restoring divider, one quotient bit per cycle, for the projection parameter.
`default_nettype none
module npos_div
  import npos_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [SQS_W-1:0]         dividend,
  input  wire logic [SQS_W-1:0]         divisor,
  output logic                          done,
  output logic      [FRACTION_BITS-1:0] quot
);

  localparam int CW = $clog2(FRACTION_BITS + 1);

  logic [SQS_W-1:0]         rem_r, rem_nxt;
  logic [SQS_W-1:0]         den_r;
  logic [FRACTION_BITS-1:0] q_r, q_nxt;
  logic [CW-1:0]            cnt_r;
  logic                     run_r;
  logic                     done_r;
  logic [SQS_W:0]           sh;
  logic                     ge;

  always_comb begin
    sh      = {rem_r, 1'b0};
    ge      = sh >= {1'b0, den_r};
    rem_nxt = ge ? SQS_W'(sh - {1'b0, den_r}) : SQS_W'(sh);
    q_nxt   = {q_r[FRACTION_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(FRACTION_BITS);
    end else if (run_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      den_r <= divisor;
      q_r   <= '0;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
`default_nettype wire

### design/nearest_point_on_segments.sv
// Top level: endpoint store, per-segment projection sequencer and result register.
//
// Input words (in_*): in_tuser = 0 writes one endpoint into slot endpoint_index,
// in_tuser = 1 queries the point (coord_x, coord_y). A write gives no output word;
// a query gives one output word on out_* with the nearest segment, the projected
// point and the squared distance (out_tuser = found).
// The user must load segment_count through cfg_we / cfg_wdata only while the
// block is idle; the block itself does not enforce this. A query walks segments
// 0..n-1 one at a time, each through ST_RD, ST_DIFF, ST_MUL, ST_SUM, ST_PROJ,
// ST_NEAR, ST_DXY, ST_SQ and ST_CMP, with ST_DIV and the bit-serial divider
// before ST_PROJ when the projection parameter needs them; the even and odd
// endpoint RAMs are read once per segment.
// The block takes a new input word only between queries; it does so even while
// an earlier result waits in the output register. A stalled receiver holds the
// finished result in the output register and the next query waits to deliver.
// Reset clears the control state and segment_count; store contents are undefined
// until written and there is no clearing pass.
`default_nettype none
`include "nearest_point_on_segments_defines.svh"
module nearest_point_on_segments
  import npos_pkg::*;
#(
  parameter int MAX_SEGMENTS  = DEF_MAX_SEGMENTS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // endpoint_index[8:0], coord_x[26:9], coord_y[44:27], zero pad
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // op
  input  wire logic                   in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // best_segment[7:0], near_x[25:8], near_y[43:26], distance_squared[80:44], pad
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  // found
  output logic                        out_tuser,
  input  wire logic                   cfg_we,
  input  wire logic [CNT_W-1:0]       cfg_wdata
);

  localparam int SEG_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int SEG_CW = $clog2(MAX_SEGMENTS + 1);
  localparam int T_W    = FRACTION_BITS + 1;
  localparam int PM_W   = T_W + 1 + DIFF_W;
  localparam int NP_W   = DIFF_W + 2;
  localparam int SQD_W  = 2 * NP_W;

  typedef enum logic [11:0] {
    ST_IDLE = 12'b000000000001,
    ST_RD   = 12'b000000000010,
    ST_DIFF = 12'b000000000100,
    ST_MUL  = 12'b000000001000,
    ST_SUM  = 12'b000000010000,
    ST_DIV  = 12'b000000100000,
    ST_PROJ = 12'b000001000000,
    ST_NEAR = 12'b000010000000,
    ST_DXY  = 12'b000100000000,
    ST_SQ   = 12'b001000000000,
    ST_CMP  = 12'b010000000000,
    ST_OUT  = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]   segment_count_r;
  logic [SEG_CW-1:0]  n_r, k_r;
  logic               found_r;
  logic [SEG_CW-1:0]  best_k_r;
  logic [COORD_W-1:0] best_x_r, best_y_r;
  logic [DIST_W-1:0]  best_d_r;

  logic               out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic               out_found_r;

  logic signed [COORD_W-1:0] px_r, py_r, s1x_r, s1y_r;
  logic signed [DIFF_W-1:0]  sx_r, sy_r, rx_r, ry_r;
  logic signed [PROD_W-1:0]  sxx_r, syy_r, rsx_r, rsy_r;
  logic        [T_W-1:0]     t_r;
  logic signed [PM_W-1:0]    pxm_r, pym_r;
  logic signed [NP_W-1:0]    nx_r, ny_r, dx_r, dy_r;
  logic signed [SQD_W-1:0]   dxx_r, dyy_r;

  logic in_acc, is_query;
  logic [IDX_W-1:0] w_slot;
  logic signed [COORD_W-1:0] w_x, w_y;
  logic ram_we, we_even, we_odd;
  logic [SEG_AW-1:0] w_addr, r_addr;
  logic [POINT_W-1:0] rd_even, rd_odd;
  logic [SEG_CW-1:0] n_clamp;

  logic [SQS_W-1:0]        sqs;
  logic signed [DOT_W-1:0] dot;
  logic div_start, div_done;
  logic [FRACTION_BITS-1:0] div_q;
  logic [DIST_W-1:0] d_cur;
  logic [SQD_W:0]    d_sum;
  logic signed [COORD_W-1:0] e_x, e_y, o_x, o_y;

  assign w_slot   = in_tdata[IDX_W-1:0];
  assign w_x      = in_tdata[IDX_W +: COORD_W];
  assign w_y      = in_tdata[IDX_W + COORD_W +: COORD_W];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign is_query = (in_tuser == OP_QUERY);

  assign ram_we  = in_acc && !is_query && (32'(w_slot) < 32'(2 * MAX_SEGMENTS));
  assign we_even = ram_we && !w_slot[0];
  assign we_odd  = ram_we && w_slot[0];
  assign w_addr  = SEG_AW'(32'(w_slot) >> 1);
  assign r_addr  = k_r[SEG_AW-1:0];

  assign n_clamp = (32'(segment_count_r) > 32'(MAX_SEGMENTS)) ?
                   SEG_CW'(MAX_SEGMENTS) : SEG_CW'(segment_count_r);

  npos_ram #(.WIDTH(POINT_W), .DEPTH(MAX_SEGMENTS)) u_ram_even (
    .clk   (clk),
    .we    (we_even),
    .waddr (w_addr),
    .wdata ({w_y, w_x}),
    .raddr (r_addr),
    .rdata (rd_even)
  );

  npos_ram #(.WIDTH(POINT_W), .DEPTH(MAX_SEGMENTS)) u_ram_odd (
    .clk   (clk),
    .we    (we_odd),
    .waddr (w_addr),
    .wdata ({w_y, w_x}),
    .raddr (r_addr),
    .rdata (rd_odd)
  );

  assign e_x = rd_even[COORD_W-1:0];
  assign e_y = rd_even[POINT_W-1:COORD_W];
  assign o_x = rd_odd[COORD_W-1:0];
  assign o_y = rd_odd[POINT_W-1:COORD_W];

  // sums of products are nonnegative for sqs, signed for dot
  assign sqs = SQS_W'(sxx_r) + SQS_W'(syy_r);
  assign dot = DOT_W'(rsx_r) + DOT_W'(rsy_r);
  assign div_start = (state_r == ST_SUM) && (sqs != '0) && (dot > 0) &&
                     (dot < $signed({1'b0, sqs}));

  npos_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dot[SQS_W-1:0]),
    .divisor  (sqs),
    .done     (div_done),
    .quot     (div_q)
  );

  assign d_sum = (SQD_W + 1)'(unsigned'(dxx_r)) + (SQD_W + 1)'(unsigned'(dyy_r));
  assign d_cur = d_sum[DIST_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc && is_query) begin
        state_nxt = (n_clamp == '0) ? ST_OUT : ST_RD;
      end
      ST_RD:   state_nxt = ST_DIFF;
      ST_DIFF: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = div_start ? ST_DIV : ST_PROJ;
      ST_DIV:  if (div_done) begin
        state_nxt = ST_PROJ;
      end
      ST_PROJ: state_nxt = ST_NEAR;
      ST_NEAR: state_nxt = ST_DXY;
      ST_DXY:  state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_CMP;
      ST_CMP:  state_nxt = (k_r + 1'b1 == n_r) ? ST_OUT : ST_RD;
      ST_OUT:  if (!out_valid_r || out_tready) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      segment_count_r <= '0;
      out_valid_r     <= 1'b0;
      found_r         <= 1'b0;
      k_r             <= '0;
      n_r             <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        segment_count_r <= cfg_wdata;
      end
      if (state_r == ST_IDLE && in_acc && is_query) begin
        n_r     <= n_clamp;
        k_r     <= '0;
        found_r <= 1'b0;
      end
      if (state_r == ST_CMP) begin
        found_r <= 1'b1;
        k_r     <= k_r + 1'b1;
      end
      if (state_r == ST_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: if (in_acc && is_query) begin
        px_r     <= w_x;
        py_r     <= w_y;
        best_k_r <= '0;
        best_x_r <= '0;
        best_y_r <= '0;
        best_d_r <= '0;
      end
      ST_DIFF: begin
        s1x_r <= e_x;
        s1y_r <= e_y;
        sx_r  <= DIFF_W'(o_x) - DIFF_W'(e_x);
        sy_r  <= DIFF_W'(o_y) - DIFF_W'(e_y);
        rx_r  <= DIFF_W'(px_r) - DIFF_W'(e_x);
        ry_r  <= DIFF_W'(py_r) - DIFF_W'(e_y);
      end
      ST_MUL: begin
        sxx_r <= sx_r * sx_r;
        syy_r <= sy_r * sy_r;
        rsx_r <= rx_r * sx_r;
        rsy_r <= ry_r * sy_r;
      end
      ST_SUM: begin
        if (sqs == '0 || dot <= 0) begin
          t_r <= '0;
        end else begin
          t_r <= T_W'(1) << FRACTION_BITS;
        end
      end
      ST_DIV: if (div_done) begin
        t_r <= {1'b0, div_q};
      end
      ST_PROJ: begin
        pxm_r <= $signed({1'b0, t_r}) * sx_r;
        pym_r <= $signed({1'b0, t_r}) * sy_r;
      end
      ST_NEAR: begin
        nx_r <= NP_W'(s1x_r) + NP_W'(pxm_r >>> FRACTION_BITS);
        ny_r <= NP_W'(s1y_r) + NP_W'(pym_r >>> FRACTION_BITS);
      end
      ST_DXY: begin
        dx_r <= NP_W'(px_r) - nx_r;
        dy_r <= NP_W'(py_r) - ny_r;
      end
      ST_SQ: begin
        dxx_r <= dx_r * dx_r;
        dyy_r <= dy_r * dy_r;
      end
      ST_CMP: if (!found_r || d_cur < best_d_r) begin
        best_d_r <= d_cur;
        best_k_r <= k_r;
        best_x_r <= nx_r[COORD_W-1:0];
        best_y_r <= ny_r[COORD_W-1:0];
      end
      ST_OUT: if (!out_valid_r || out_tready) begin
        out_found_r <= found_r;
        out_data_r  <= {7'b0, best_d_r, best_y_r, best_x_r, SEG_OUT_W'(best_k_r)};
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_found_r;

  `NPOS_ASSERT_IMP(a_wr_idle, ram_we, state_r == ST_IDLE, "store write outside idle")
  `NPOS_ASSERT_IMP(a_rd_range, state_r == ST_RD, k_r < n_r, "segment read past count")
  `NPOS_ASSERT_NXT(a_div_enter, div_start, state_r == ST_DIV, "divider start lost")
  `NPOS_ASSERT_IMP(a_found, state_r == ST_OUT, found_r == (n_r != '0), "found flag wrong")
  `NPOS_ASSERT_NXT(a_out_load, (state_r == ST_OUT) && (!out_valid_r || out_tready),
                   out_valid_r && (state_r == ST_IDLE), "result not loaded")

endmodule
`default_nettype wire

### bench/tb_top.sv
// Testbench for nearest_point_on_segments: queued driver, checking monitor, scalar predictor.
`default_nettype none
module tb_top;
  import npos_pkg::*;

  typedef struct {
    logic                      op;
    logic [IDX_W-1:0]          slot;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
  } word_t;

  typedef struct {
    logic                      found;
    logic [SEG_OUT_W-1:0]      seg;
    logic signed [COORD_W-1:0] nx;
    logic signed [COORD_W-1:0] ny;
    logic [DIST_W-1:0]         dsq;
  } nearest_t;

  localparam int SLOTS = 2 * DEF_MAX_SEGMENTS;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_we = 1'b0;
  logic [CNT_W-1:0]       cfg_wdata = '0;

  word_t      pending_words[$];
  nearest_t   nearest_expected[$];
  word_t      cur_word;
  longint     store_x[SLOTS];
  longint     store_y[SLOTS];
  bit         slot_written[SLOTS];
  int         seg_count_model = 0;
  int         idle_mode = 0;
  int         mismatches = 0;

  nearest_point_on_segments uut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .cfg_we, .cfg_wdata
  );

  always #10 clk = ~clk;

  initial begin
    #200_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic nearest_t find_nearest(longint qx, longint qy);
    nearest_t r;
    longint n, sx, sy, rx, ry, sqs, dot, t, ex, ey, dx, dy, d, best_d;
    r = '{1'b0, '0, '0, '0, '0};
    best_d = 0;
    n = (seg_count_model > DEF_MAX_SEGMENTS) ? DEF_MAX_SEGMENTS : seg_count_model;
    for (int k = 0; k < n; k++) begin
      sx = store_x[2*k+1] - store_x[2*k];
      sy = store_y[2*k+1] - store_y[2*k];
      rx = qx - store_x[2*k];
      ry = qy - store_y[2*k];
      sqs = sx * sx + sy * sy;
      dot = rx * sx + ry * sy;
      if (sqs <= 0 || dot <= 0) t = 0;
      else if (dot >= sqs) t = 64'sd1 <<< DEF_FRACTION_BITS;
      else t = (dot <<< DEF_FRACTION_BITS) / sqs;
      ex = store_x[2*k] + ((t * sx) >>> DEF_FRACTION_BITS);
      ey = store_y[2*k] + ((t * sy) >>> DEF_FRACTION_BITS);
      dx = qx - ex;
      dy = qy - ey;
      d = dx * dx + dy * dy;
      if (!r.found || d < best_d) begin
        r.found = 1'b1;
        best_d = d;
        r.seg = k[SEG_OUT_W-1:0];
        r.nx = ex[COORD_W-1:0];
        r.ny = ey[COORD_W-1:0];
        r.dsq = d[DIST_W-1:0];
      end
    end
    return r;
  endfunction

  task automatic apply_word(word_t w);
    if (w.op == OP_WRITE) begin
      store_x[w.slot] = w.px;
      store_y[w.slot] = w.py;
      slot_written[w.slot] = 1'b1;
    end else begin
      nearest_expected.insert(nearest_expected.size(), find_nearest(w.px, w.py));
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) apply_word(cur_word);
      if (!in_tvalid || in_tready) begin
        if (pending_words.size() > 0 &&
            !((idle_mode == 1 && $urandom_range(99) < 45) ||
              (idle_mode == 3 && $urandom_range(99) < 22))) begin
          cur_word = pending_words.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= cur_word.op;
          in_tdata <= {{(IN_TDATA_W-IDX_W-2*COORD_W){1'b0}},
                       cur_word.py, cur_word.px, cur_word.slot};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    mismatches++;
  endtask

  // receiver and checker
  always @(posedge clk) begin
    nearest_t e;
    if (rst_n) begin
      out_tready <= !((idle_mode == 2 && $urandom_range(99) < 45) ||
                      (idle_mode == 3 && $urandom_range(99) < 22));
      if (out_tvalid && out_tready) begin
        if (nearest_expected.size() == 0) begin
          report("unexpected word", out_tdata[43:0], 0);
        end else begin
          e = nearest_expected.pop_front();
          if (out_tuser !== e.found) report("found", out_tuser, e.found);
          if (out_tdata[7:0] !== e.seg) report("best_segment", out_tdata[7:0], e.seg);
          if (out_tdata[25:8] !== e.nx) report("near_x", out_tdata[25:8], e.nx);
          if (out_tdata[43:26] !== e.ny) report("near_y", out_tdata[43:26], e.ny);
          if (out_tdata[80:44] !== e.dsq)
            report("distance_squared", out_tdata[80:44], e.dsq);
        end
      end
    end
  end

  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(5))
      0: return 18'sh20000;
      1: return 18'sh1ffff;
      2: return COORD_W'($urandom_range(2047) - 1024);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  task automatic push(logic op, int slot, logic signed [COORD_W-1:0] x,
                      logic signed [COORD_W-1:0] y);
    word_t w;
    w.op = op;
    w.slot = slot[IDX_W-1:0];
    w.px = x;
    w.py = y;
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_tvalid || nearest_expected.size() != 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_count(int v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v[CNT_W-1:0];
    seg_count_model = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int n, k;
    logic signed [COORD_W-1:0] cx, cy;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty set, then degenerate, extreme and tied duplicate segments
    set_count(0);
    push(OP_QUERY, 0, 18'sh1ffff, 18'sh20000);
    push(OP_WRITE, 0, 18'sh00100, 18'sh00200);
    push(OP_WRITE, 1, 18'sh00100, 18'sh00200);
    push(OP_WRITE, 2, 18'sh20000, 18'sh20000);
    push(OP_WRITE, 3, 18'sh1ffff, 18'sh1ffff);
    push(OP_WRITE, 4, 18'sh20000, 18'sh20000);
    push(OP_WRITE, 5, 18'sh1ffff, 18'sh1ffff);
    drain();
    set_count(3);
    push(OP_QUERY, 0, 18'sh20000, 18'sh20000);
    push(OP_QUERY, 0, 18'sh1ffff, 18'sh1ffff);
    push(OP_QUERY, 0, 18'sh20000, 18'sh1ffff);
    push(OP_QUERY, 0, 18'sh1ffff, 18'sh20000);
    push(OP_QUERY, 0, 18'sh00100, 18'sh00200);
    push(OP_QUERY, 0, 18'sh00000, 18'sh00000);
    push(OP_QUERY, 0, 18'sh00123, 18'sh3fedc);
    drain();

    // fill the whole store, then full and over-range counts
    for (int s = 0; s < SLOTS; s++) push(OP_WRITE, s, pick_coord(), pick_coord());
    drain();
    set_count(511);
    push(OP_QUERY, 0, pick_coord(), pick_coord());
    push(OP_QUERY, 0, pick_coord(), pick_coord());
    drain();
    set_count(256);
    push(OP_QUERY, 0, pick_coord(), pick_coord());
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      idle_mode = ph % 4;
      case (ph)
        0: n = 0;
        5: n = 1;
        default: n = $urandom_range(8, 1);
      endcase
      if (ph == 7) n = 257 + $urandom_range(254);
      set_count(n);
      if (n > 256) n = 256;
      for (int i = 0; i < 45; i++) begin
        k = (n > 0) ? $urandom_range(n - 1) : 0;
        case ($urandom_range(9))
          0, 1: push(OP_QUERY, 0, pick_coord(), pick_coord());
          2: push(OP_WRITE, $urandom_range(SLOTS - 1), pick_coord(), pick_coord());
          3: begin
            cx = pick_coord();
            cy = pick_coord();
            push(OP_WRITE, 2*k, cx, cy);
            push(OP_WRITE, 2*k + 1, cx, cy);
            push(OP_QUERY, 0, pick_coord(), pick_coord());
          end
          default: begin
            push(OP_WRITE, 2*k, pick_coord(), pick_coord());
            push(OP_WRITE, 2*k + 1, pick_coord(), pick_coord());
            push(OP_QUERY, 0, pick_coord(), pick_coord());
          end
        endcase
        if (ph == 7 && i == 3) break;
      end
      drain();
    end

    idle_mode = 0;
    repeat (100) @(posedge clk);
    if (mismatches == 0 && nearest_expected.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
+incdir+design
design/npos_pkg.sv
design/npos_ram.sv
design/npos_div.sv
design/nearest_point_on_segments.sv
bench/tb_top.sv
